>>> sv/text_console_writer_macros.svh
// assertion macros for the text console writer top level
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define TCW_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("text console writer: check failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("text console writer: check failed");

`endif

>>> sv/tcw_pkg.sv
// shared types and constants of the text console writer
`default_nettype none

package tcw_pkg;

  // character and attribute constants
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_SPACE     = 8'd32;
  localparam logic [7:0] ATTR_RESET     = 8'd15;

  // operation codes on the input channel
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } tcw_op_e;

  // classified command between front and back
  typedef enum logic [2:0] {
    CMD_PUT_CHAR  = 3'd0,
    CMD_NEWLINE   = 3'd1,
    CMD_BACKSPACE = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_READ      = 3'd4,
    CMD_NOP       = 3'd5
  } tcw_cmd_e;

  typedef struct packed {
    tcw_op_e     op;
    logic        at_position;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
    logic [7:0]  cell_code;
    logic [7:0]  cell_attribute;
  } tcw_out_t;

  // position already saturated, attribute already resolved
  typedef struct packed {
    tcw_cmd_e    kind;
    logic        at_position;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
  } tcw_cmd_t;

endpackage

`default_nettype wire

>>> sv/tcw_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/tcw_cmd_queue.sv
// short command queue between the front and the back
`default_nettype none

module tcw_cmd_queue import tcw_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire tcw_cmd_t data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output tcw_cmd_t      data_o,
  output logic          empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  tcw_cmd_t            entries_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/tcw_front.sv
// input side: accepts transfers, saturates positions and classifies commands
`default_nettype none

module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire tcw_in_t    in_data_i,
  input  wire logic [7:0] default_attr_i,
  input  wire logic       init_busy_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output tcw_cmd_t        cmd_o
);

  logic [6:0] col_sat;
  logic [4:0] row_sat;

  // hold off while the queue is full or the store is being blanked after reset
  assign in_stall_o = q_full_i | init_busy_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  // clamp the given position to the screen
  always_comb begin
    col_sat = in_data_i.col;
    row_sat = in_data_i.row;
    if (int'(in_data_i.col) > COLUMNS - 1) begin
      col_sat = 7'(COLUMNS - 1);
    end
    if (int'(in_data_i.row) > ROWS - 1) begin
      row_sat = 5'(ROWS - 1);
    end
  end

  // classify the operation
  always_comb begin
    cmd_o.at_position = in_data_i.at_position;
    cmd_o.col         = col_sat;
    cmd_o.row         = row_sat;
    cmd_o.char_code   = in_data_i.char_code;
    cmd_o.attribute   = (in_data_i.attribute == '0) ? default_attr_i : in_data_i.attribute;
    unique case (in_data_i.op)
      OP_PUT: begin
        if (in_data_i.char_code == CHAR_NEWLINE) begin
          cmd_o.kind = CMD_NEWLINE;
        end else if (in_data_i.char_code == CHAR_BACKSPACE) begin
          cmd_o.kind = CMD_BACKSPACE;
        end else begin
          cmd_o.kind = CMD_PUT_CHAR;
        end
      end
      OP_CLEAR: cmd_o.kind = CMD_CLEAR;
      OP_READ:  cmd_o.kind = CMD_READ;
      default:  cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/tcw_back.sv
// execution side: cursor, row rotation, cell store, blanking sweeps and result register
`default_nettype none

module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] default_attr_i,
  input  wire tcw_cmd_t   cmd_i,
  input  wire logic       cmd_empty_i,
  output logic            cmd_pop_o,
  output logic            init_busy_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output tcw_out_t        out_data_o
);

  localparam int CellCount = COLUMNS * ROWS;
  localparam int ColW      = $clog2(COLUMNS);
  localparam int RowW      = $clog2(ROWS);
  localparam int AddrW     = $clog2(CellCount);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_RDATA = 4'b1000
  } tcw_state_e;

  typedef enum logic [1:0] {
    SW_INIT   = 2'd0,
    SW_CLEAR  = 2'd1,
    SW_SCROLL = 2'd2
  } tcw_sweep_e;

  tcw_state_e        state_q, state_d;
  tcw_sweep_e        sweep_kind_q, sweep_kind_d;
  logic [ColW-1:0]   cur_col_q, cur_col_d;
  logic [RowW-1:0]   cur_row_q, cur_row_d;
  logic [RowW-1:0]   base_q, base_d;
  logic [AddrW-1:0]  sweep_addr_q, sweep_addr_d;
  logic [AddrW-1:0]  sweep_last_q, sweep_last_d;
  logic              out_valid_q, out_valid_d;
  tcw_out_t          out_q, out_d;
  logic [ColW-1:0]   tgt_col_q, tgt_col_d;
  logic [RowW-1:0]   tgt_row_q, tgt_row_d;
  logic [15:0]       wdata_q, wdata_d;
  tcw_cmd_e          kind_q, kind_d;
  logic              do_write_q, do_write_d;
  logic              scroll_q, scroll_d;

  // decode of the command at the queue head
  logic [ColW-1:0]   pos_col, nxt_col, sel_col;
  logic [RowW-1:0]   pos_row, nxt_row, sel_row;
  logic              at_last_col, at_last_row;
  logic              sel_write, sel_scroll;
  logic [15:0]       sel_data;

  // address path
  logic [RowW:0]     row_sum;
  logic [RowW-1:0]   phys_row;
  logic [AddrW-1:0]  cell_addr;
  logic [AddrW-1:0]  row_start;
  logic [RowW-1:0]   base_next;
  logic [7:0]        sweep_attr;
  tcw_out_t          res_base;

  // ram port
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr;
  logic [15:0]       ram_wdata, ram_rdata;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CellCount)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cell_addr),
    .rdata_o (ram_rdata)
  );

  assign cmd_pop_o   = (state_q == ST_IDLE) && !out_valid_q && !cmd_empty_i;
  assign init_busy_o = (state_q == ST_SWEEP) && (sweep_kind_q == SW_INIT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // target cell and next cursor of the head command
  always_comb begin
    pos_col     = cmd_i.at_position ? ColW'(cmd_i.col) : cur_col_q;
    pos_row     = cmd_i.at_position ? RowW'(cmd_i.row) : cur_row_q;
    at_last_col = (pos_col == ColW'(COLUMNS - 1));
    at_last_row = (pos_row == RowW'(ROWS - 1));
    nxt_col     = cur_col_q;
    nxt_row     = cur_row_q;
    sel_col     = pos_col;
    sel_row     = pos_row;
    sel_write   = 1'b0;
    sel_scroll  = 1'b0;
    sel_data    = {cmd_i.attribute, cmd_i.char_code};
    case (cmd_i.kind)
      CMD_PUT_CHAR: begin
        sel_write = 1'b1;
        if (at_last_col) begin
          nxt_col = '0;
          if (at_last_row) begin
            sel_scroll = 1'b1;
            nxt_row    = pos_row;
          end else begin
            nxt_row = pos_row + 1'b1;
          end
        end else begin
          nxt_col = pos_col + 1'b1;
          nxt_row = pos_row;
        end
      end
      CMD_NEWLINE: begin
        nxt_col = '0;
        if (at_last_row) begin
          sel_scroll = 1'b1;
          nxt_row    = pos_row;
        end else begin
          nxt_row = pos_row + 1'b1;
        end
      end
      CMD_BACKSPACE: begin
        sel_data = {cmd_i.attribute, CHAR_SPACE};
        if (pos_col == '0 && pos_row == '0) begin
          // at the origin nothing is blanked
          nxt_col = '0;
          nxt_row = '0;
        end else begin
          sel_write = 1'b1;
          if (pos_col == '0) begin
            nxt_col = ColW'(COLUMNS - 1);
            nxt_row = pos_row - 1'b1;
          end else begin
            nxt_col = pos_col - 1'b1;
            nxt_row = pos_row;
          end
          sel_col = nxt_col;
          sel_row = nxt_row;
        end
      end
      CMD_CLEAR: begin
        nxt_col = '0;
        nxt_row = '0;
      end
      default: ;
    endcase
  end

  // logical row to physical row through the rotation base
  always_comb begin
    row_sum   = {1'b0, tgt_row_q} + {1'b0, base_q};
    phys_row  = (row_sum >= (RowW+1)'(ROWS)) ? RowW'(row_sum - (RowW+1)'(ROWS))
                                              : RowW'(row_sum);
    cell_addr = AddrW'(phys_row) * AddrW'(COLUMNS) + AddrW'(tgt_col_q);
    row_start = AddrW'(base_q) * AddrW'(COLUMNS);
    base_next = (base_q == RowW'(ROWS - 1)) ? '0 : base_q + 1'b1;
    sweep_attr = (sweep_kind_q == SW_INIT) ? ATTR_RESET : default_attr_i;
    res_base.cursor_col     = 7'(cur_col_q);
    res_base.cursor_row     = 5'(cur_row_q);
    res_base.scrolled       = 1'b0;
    res_base.cell_code      = '0;
    res_base.cell_attribute = '0;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    sweep_kind_d = sweep_kind_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    base_d       = base_q;
    sweep_addr_d = sweep_addr_q;
    sweep_last_d = sweep_last_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_d        = out_q;
    tgt_col_d    = tgt_col_q;
    tgt_row_d    = tgt_row_q;
    wdata_d      = wdata_q;
    kind_d       = kind_q;
    do_write_d   = do_write_q;
    scroll_d     = scroll_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = cell_addr;
    ram_wdata    = wdata_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          cur_col_d  = nxt_col;
          cur_row_d  = nxt_row;
          tgt_col_d  = sel_col;
          tgt_row_d  = sel_row;
          wdata_d    = sel_data;
          kind_d     = cmd_i.kind;
          do_write_d = sel_write;
          scroll_d   = sel_scroll;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (kind_q == CMD_CLEAR) begin
          base_d       = '0;
          sweep_addr_d = '0;
          sweep_last_d = AddrW'(CellCount - 1);
          sweep_kind_d = SW_CLEAR;
          state_d      = ST_SWEEP;
        end else if (kind_q == CMD_READ) begin
          ram_re  = 1'b1;
          state_d = ST_RDATA;
        end else begin
          ram_we = do_write_q;
          if (scroll_q) begin
            // the old top row becomes the blank bottom row
            base_d       = base_next;
            sweep_addr_d = row_start;
            sweep_last_d = row_start + AddrW'(COLUMNS - 1);
            sweep_kind_d = SW_SCROLL;
            state_d      = ST_SWEEP;
          end else begin
            out_valid_d = 1'b1;
            out_d       = res_base;
            state_d     = ST_IDLE;
          end
        end
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr_q;
        ram_wdata = {sweep_attr, CHAR_SPACE};
        if (sweep_addr_q == sweep_last_q) begin
          if (sweep_kind_q != SW_INIT) begin
            out_valid_d    = 1'b1;
            out_d          = res_base;
            out_d.scrolled = (sweep_kind_q == SW_SCROLL);
          end
          state_d = ST_IDLE;
        end else begin
          sweep_addr_d = sweep_addr_q + 1'b1;
        end
      end
      ST_RDATA: begin
        out_valid_d          = 1'b1;
        out_d                = res_base;
        out_d.cell_code      = ram_rdata[7:0];
        out_d.cell_attribute = ram_rdata[15:8];
        state_d              = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, blanking pass starts out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      sweep_kind_q <= SW_INIT;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      base_q       <= '0;
      sweep_addr_q <= '0;
      sweep_last_q <= AddrW'(CellCount - 1);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_kind_q <= sweep_kind_d;
      cur_col_q    <= cur_col_d;
      cur_row_q    <= cur_row_d;
      base_q       <= base_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_last_q <= sweep_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    tgt_col_q  <= tgt_col_d;
    tgt_row_q  <= tgt_row_d;
    wdata_q    <= wdata_d;
    kind_q     <= kind_d;
    do_write_q <= do_write_d;
    scroll_q   <= scroll_d;
  end

endmodule

`default_nettype wire

>>> sv/text_console_writer.sv
// text console writer top level: config register, front, command queue, back
// a command passes the command queue, then the back idle and exec states; a read also passes rdata
// a scroll blanks one row and a clear the whole store in the sweep state, one blank write per cycle
// the back sequencer takes a new command only in idle and once its last result has been taken
// reset: cursor homed, attribute 15, store blanked in a sweep pass, input stalled
`default_nettype none
`include "text_console_writer_macros.svh"

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire tcw_in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output tcw_out_t        out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  logic [7:0] default_attr_q, default_attr_d;
  logic       init_busy;
  logic       q_push, q_full, q_pop, q_empty;
  tcw_cmd_t   front_cmd, head_cmd;

  // default attribute register
  assign default_attr_d = cfg_we_i ? cfg_wdata_i : default_attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_attr_q <= ATTR_RESET;
    end else begin
      default_attr_q <= default_attr_d;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .default_attr_i (default_attr_q),
    .init_busy_i    (init_busy),
    .q_full_i       (q_full),
    .push_o         (q_push),
    .cmd_o          (front_cmd)
  );

  tcw_cmd_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (head_cmd),
    .empty_o (q_empty)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .default_attr_i (default_attr_q),
    .cmd_i          (head_cmd),
    .cmd_empty_i    (q_empty),
    .cmd_pop_o      (q_pop),
    .init_busy_o    (init_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

  // checks
  `TCW_ASSERT_HOLDS(a_push_not_full, q_push, !q_full)
  `TCW_ASSERT_NEXT(a_push_fills, q_push, !q_empty)
  `TCW_ASSERT_HOLDS(a_no_result_in_init, init_busy, !out_valid_o && !q_pop)
  `TCW_ASSERT_HOLDS(a_scroll_homes_col, out_valid_o && out_data_o.scrolled,
                    (out_data_o.cursor_col == '0) && (out_data_o.cell_code == '0) &&
                    (out_data_o.cell_attribute == '0))
  `TCW_ASSERT_HOLDS(a_cursor_in_range, out_valid_o,
                    (int'(out_data_o.cursor_col) < COLUMNS) &&
                    (int'(out_data_o.cursor_row) < ROWS))

endmodule

`default_nettype wire

>>> tb/tcw_result_check.sv
`timescale 1ns / 100ps
// result checker for the text console writer: predicts each result and compares it
module tcw_result_check import tcw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  tcw_in_t    in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  tcw_out_t   out_data_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_count_o,
  output int         scroll_count_o
);

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // shadow copy of the screen: attribute in the high byte, character in the low byte
  logic [15:0] screen_cells [CELL_COUNT];
  int unsigned cursor_pos;
  logic [7:0]  default_attr;

  // predicted cursor and cell status, oldest first
  tcw_out_t    predicted_status_q [$];
  tcw_out_t    want_status;
  int          fail_count;
  int          checked_count;
  int          scroll_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = {default_attr, CHAR_SPACE};
  endfunction

  // given column and row, clamped to the last column and row
  function automatic int unsigned target_cell(tcw_in_t item);
    int unsigned c;
    int unsigned r;
    c = (item.col > COLUMNS - 1) ? COLUMNS - 1 : item.col;
    r = (item.row > ROWS - 1) ? ROWS - 1 : item.row;
    return r * COLUMNS + c;
  endfunction

  // apply one command to the shadow console and return the status it reports
  function automatic tcw_out_t advance_console(tcw_in_t item);
    tcw_out_t    res;
    int unsigned pos;
    logic [7:0]  attr;
    res = '0;
    if (cursor_pos >= CELL_COUNT) cursor_pos = 0;
    case (item.op)
      OP_PUT: begin
        pos  = item.at_position ? target_cell(item) : cursor_pos;
        attr = (item.attribute == 8'd0) ? default_attr : item.attribute;
        if (item.char_code == CHAR_NEWLINE) begin
          pos = (pos / COLUMNS + 1) * COLUMNS;
        end else if (item.char_code == CHAR_BACKSPACE) begin
          // nothing to erase at the origin
          if (pos > 0) begin
            pos--;
            screen_cells[pos] = {attr, CHAR_SPACE};
          end
        end else begin
          screen_cells[pos] = {attr, item.char_code};
          pos++;
        end
        // ran past the last cell: shift rows up and blank the bottom row
        if (pos >= CELL_COUNT) begin
          for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen_cells[i] = screen_cells[i + COLUMNS];
          for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
            screen_cells[i] = {default_attr, CHAR_SPACE};
          end
          pos -= COLUMNS;
          res.scrolled = 1'b1;
          scroll_count++;
        end
        cursor_pos = pos;
      end
      OP_CLEAR: begin
        blank_screen();
        cursor_pos = 0;
      end
      OP_READ: begin
        pos = item.at_position ? target_cell(item) : cursor_pos;
        res.cell_code      = screen_cells[pos][7:0];
        res.cell_attribute = screen_cells[pos][15:8];
      end
      default: ;
    endcase
    res.cursor_col = 7'(cursor_pos % COLUMNS);
    res.cursor_row = 5'(cursor_pos / COLUMNS);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_attr = ATTR_RESET;
      cursor_pos   = 0;
      blank_screen();
      predicted_status_q.delete();
    end else begin
      // register write
      if (cfg_we_i) default_attr = cfg_wdata_i;

      // result transfer against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (predicted_status_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no command pending", out_data_i));
        end else begin
          want_status = predicted_status_q.pop_front();
          checked_count++;
          if (out_data_i.cursor_col !== want_status.cursor_col)
            report_mismatch($sformatf("cursor_col %0d, expected %0d",
                                      out_data_i.cursor_col, want_status.cursor_col));
          if (out_data_i.cursor_row !== want_status.cursor_row)
            report_mismatch($sformatf("cursor_row %0d, expected %0d",
                                      out_data_i.cursor_row, want_status.cursor_row));
          if (out_data_i.scrolled !== want_status.scrolled)
            report_mismatch($sformatf("scrolled %b, expected %b",
                                      out_data_i.scrolled, want_status.scrolled));
          if (out_data_i.cell_code !== want_status.cell_code)
            report_mismatch($sformatf("cell_code %h, expected %h",
                                      out_data_i.cell_code, want_status.cell_code));
          if (out_data_i.cell_attribute !== want_status.cell_attribute)
            report_mismatch($sformatf("cell_attribute %h, expected %h",
                                      out_data_i.cell_attribute, want_status.cell_attribute));
        end
      end

      // command transfer
      if (in_valid_i && !in_stall_i) predicted_status_q.push_back(advance_console(in_data_i));
    end
    fail_count_o    <= fail_count;
    pending_o       <= predicted_status_q.size();
    checked_count_o <= checked_count;
    scroll_count_o  <= scroll_count;
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// testbench top for the text console writer: clock, reset, stimulus and verdict
module testbench;
  import tcw_pkg::*;

  // op encoding the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // a full screen blank plus pipeline slack
  localparam int SETTLE_CYCLES  = 2016;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 220;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  tcw_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  tcw_out_t   out_data;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = ATTR_RESET;

  int fail_count;
  int pending;
  int checked_count;
  int scroll_count;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  int items_sent    = 0;
  int attr_settings = 0;

  text_console_writer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  tcw_result_check i_result_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_count_o (checked_count),
    .scroll_count_o  (scroll_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic tcw_in_t make_command(logic [1:0] op, logic at, logic [6:0] col,
                                           logic [4:0] row, logic [7:0] ch, logic [7:0] attr);
    tcw_in_t c;
    c.op          = tcw_op_e'(op);
    c.at_position = at;
    c.col         = col;
    c.row         = row;
    c.char_code   = ch;
    c.attribute   = attr;
    return c;
  endfunction

  // one command transfer, with random idle cycles ahead of it
  task automatic send_command(input tcw_in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // hold off until every predicted result is back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new attribute and idling mix, then a clear and random traffic
  task automatic run_phase(input int idle, input int stall, input logic [7:0] attr);
    tcw_in_t item;
    int      sel;
    int      ch_sel;
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= attr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    attr_settings++;
    idle_pct  = idle;
    stall_pct = stall;
    send_command(make_command(OP_CLEAR, 1'b0, 7'd0, 5'd0, 8'd0, 8'd0));
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      sel = $urandom_range(99);
      item.at_position = 1'($urandom_range(1));
      item.col = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(79));
      item.row = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(24));
      item.char_code = 8'($urandom_range(255));
      item.attribute = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
      if (sel < 1) begin
        item.op = OP_CLEAR;
      end else if (sel < 3) begin
        item.op = tcw_op_e'(OP_UNUSED);
      end else if (sel < 22) begin
        item.op = OP_READ;
      end else begin
        // mostly text at the cursor, with line control mixed in
        item.op          = OP_PUT;
        item.at_position = ($urandom_range(4) == 0);
        ch_sel           = $urandom_range(9);
        if (ch_sel == 0) item.char_code = CHAR_NEWLINE;
        else if (ch_sel == 1) item.char_code = CHAR_BACKSPACE;
      end
      send_command(item);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners with the reset attribute
    send_command(make_command(OP_READ, 1'b1, 7'd0, 5'd0, 8'd0, 8'd0));
    send_command(make_command(OP_READ, 1'b1, 7'd127, 5'd31, 8'hFF, 8'hFF));
    send_command(make_command(OP_PUT, 1'b0, 7'd0, 5'd0, 8'h41, 8'h00));
    send_command(make_command(OP_PUT, 1'b0, 7'd0, 5'd0, 8'hFF, 8'hFF));
    // last cell written: scroll
    send_command(make_command(OP_PUT, 1'b1, 7'd79, 5'd24, 8'h00, 8'h01));
    send_command(make_command(OP_READ, 1'b1, 7'd79, 5'd23, 8'd0, 8'd0));
    send_command(make_command(OP_READ, 1'b1, 7'd0, 5'd0, 8'd0, 8'd0));
    // newline on the bottom row scrolls again
    send_command(make_command(OP_PUT, 1'b0, 7'd0, 5'd0, CHAR_NEWLINE, 8'h00));
    // backspace at the start of a row wraps to the row above
    send_command(make_command(OP_PUT, 1'b0, 7'd0, 5'd0, CHAR_BACKSPACE, 8'h00));
    send_command(make_command(OP_PUT, 1'b0, 7'd0, 5'd0, CHAR_BACKSPACE, 8'h80));
    send_command(make_command(OP_READ, 1'b0, 7'd0, 5'd0, 8'd0, 8'd0));
    send_command(make_command(OP_CLEAR, 1'b1, 7'd127, 5'd31, 8'hFF, 8'hFF));
    // backspace at the origin does nothing
    send_command(make_command(OP_PUT, 1'b0, 7'd0, 5'd0, CHAR_BACKSPACE, 8'h7F));
    send_command(make_command(OP_PUT, 1'b1, 7'd0, 5'd0, CHAR_BACKSPACE, 8'h00));
    send_command(make_command(OP_PUT, 1'b1, 7'd127, 5'd0, 8'hAA, 8'h55));
    send_command(make_command(OP_PUT, 1'b1, 7'd5, 5'd31, CHAR_NEWLINE, 8'h00));
    send_command(make_command(OP_UNUSED, 1'b1, 7'd127, 5'd31, 8'hFF, 8'hFF));
    send_command(make_command(OP_READ, 1'b1, 7'd79, 5'd0, 8'd0, 8'd0));
    send_command(make_command(OP_PUT, 1'b1, 7'd42, 5'd10, 8'h55, 8'hAA));
    send_command(make_command(OP_READ, 1'b1, 7'd42, 5'd10, 8'd0, 8'd0));

    // random traffic under each idling mix and attribute setting
    run_phase(0, 0, 8'h00);
    run_phase(53, 0, 8'hFF);
    run_phase(0, 53, 8'($urandom_range(1, 254)));
    run_phase(32, 32, ATTR_RESET);
    drain();

    $display("covered %0d commands: puts, line control, reads, clears, unused op", items_sent);
    $display("%0d results checked, %0d scrolls, %0d attribute settings",
             checked_count, scroll_count, attr_settings);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
